>>> rtl/bbsf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO.
// Used by the channel interfaces and every module of the block; no dependencies.
package bbsf_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 13;
    localparam int unsigned TOT_W     = 64;

    // Default storage depth and capacity after reset
    localparam int unsigned DEPTH_DEF = 4096;
    localparam int unsigned CAP_RESET = 4096;

    // Request command codes
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // One request as held in the input register
    typedef struct packed {
        t_cmd              command;
        logic [BYTE_W-1:0] push_byte;
        logic [CNT_W-1:0]  pop_count;
        logic              close_stream;
        logic              raise_error;
    } t_item;

    // Status flags of one result
    typedef struct packed {
        logic push_accepted;
        logic head_valid;
        logic closed;
        logic finished;
        logic error;
    } t_status;

endpackage

>>> rtl/bbsf_if.sv
// Request, response and configuration channel interfaces of the byte FIFO.
// Depends on bbsf_pkg for field widths and the command type.
interface bbsf_req_if;
    logic                            valid;
    logic                            ready;
    bbsf_pkg::t_cmd                  command;
    logic [bbsf_pkg::BYTE_W-1:0]     push_byte;
    logic [bbsf_pkg::CNT_W-1:0]      pop_count;
    logic                            close_stream;
    logic                            raise_error;

    modport source (output valid, command, push_byte, pop_count, close_stream, raise_error,
                    input ready);
    modport sink   (input valid, command, push_byte, pop_count, close_stream, raise_error,
                    output ready);
endinterface

interface bbsf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            push_accepted;
    logic [bbsf_pkg::BYTE_W-1:0]     head_byte;
    logic                            head_valid;
    logic [bbsf_pkg::CNT_W-1:0]      occupancy;
    logic [bbsf_pkg::CNT_W-1:0]      free_space;
    logic [bbsf_pkg::TOT_W-1:0]      total_pushed;
    logic [bbsf_pkg::TOT_W-1:0]      total_popped;
    logic                            closed_flag;
    logic                            finished_flag;
    logic                            error_flag;

    modport source (output valid, push_accepted, head_byte, head_valid, occupancy, free_space,
                    total_pushed, total_popped, closed_flag, finished_flag, error_flag,
                    input ready);
    modport sink   (input valid, push_accepted, head_byte, head_valid, occupancy, free_space,
                    total_pushed, total_popped, closed_flag, finished_flag, error_flag,
                    output ready);
endinterface

interface bbsf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bbsf_pkg::CNT_W-1:0]      capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink   (input valid, capacity_limit, output ready);
endinterface

>>> rtl/bbsf_store.sv
// Byte storage of the FIFO: one write port and one registered read port.
// A read of the address written in the same cycle returns the new byte.
module bbsf_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bbsf_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [bbsf_pkg::BYTE_W-1:0] o_rd_data
);
    import bbsf_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_fwd_data;
    logic              r_fwd;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; the output holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    // Forward the byte written alongside the read, as the array still holds the old one.
    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

>>> rtl/bbsf_state.sv
// Pointer, count, total and flag state of the FIFO with its one-pass update logic.
// Depends on bbsf_pkg; drives the write and read addresses of bbsf_store.
module bbsf_state #(
    parameter int unsigned MAX_DEPTH = 4096,
    parameter int unsigned PW        = $clog2(MAX_DEPTH),
    parameter int unsigned CW        = $clog2(MAX_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  bbsf_pkg::t_item             i_item,
    input  logic                        i_cfg_we,
    input  logic [bbsf_pkg::CNT_W-1:0]  i_cfg_cap,
    output logic                        o_wr_en,
    output logic [PW-1:0]               o_wr_addr,
    output logic [PW-1:0]               o_rd_addr,
    output logic [bbsf_pkg::CNT_W-1:0]  o_occupancy,
    output logic [bbsf_pkg::CNT_W-1:0]  o_free_space,
    output logic [bbsf_pkg::TOT_W-1:0]  o_total_pushed,
    output logic [bbsf_pkg::TOT_W-1:0]  o_total_popped,
    output bbsf_pkg::t_status           o_status
);
    import bbsf_pkg::*;

    localparam int unsigned CMPW    = (CW > CNT_W) ? CW : CNT_W;
    localparam int unsigned SW      = CW + 1;
    localparam int unsigned CAP_RST = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_cap, n_cap;
    logic [TOT_W-1:0] r_pushed, n_pushed;
    logic [TOT_W-1:0] r_popped, n_popped;
    logic             r_closed, n_closed;
    logic             r_error, n_error;

    logic             is_push;
    logic             push_ok;
    logic [CW-1:0]    pop_n;
    logic [CMPW-1:0]  count_ext;
    logic [CMPW-1:0]  fill_ext;
    logic [CMPW-1:0]  cap_ext;
    logic [SW-1:0]    rp_sum;
    logic [CW-1:0]    free_n;

    // Effective capacity is the written limit saturated at the storage depth.
    always_comb begin
        cap_ext = CMPW'(i_cfg_cap);
        n_cap   = r_cap;
        if (i_cfg_we) begin
            n_cap = (cap_ext > CMPW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(i_cfg_cap);
        end
    end

    // Next state for the request in the input register.
    always_comb begin
        is_push   = (i_item.command == CMD_PUSH);
        push_ok   = is_push && (r_fill < r_cap);
        count_ext = CMPW'(i_item.pop_count);
        fill_ext  = CMPW'(r_fill);

        // A pop never removes more than is buffered.
        pop_n = '0;
        if (!is_push) begin
            pop_n = (count_ext > fill_ext) ? r_fill : CW'(i_item.pop_count);
        end

        n_fill = push_ok ? (r_fill + CW'(1)) : (r_fill - pop_n);

        // Read pointer advances by the pop count, wrapping once at most.
        rp_sum = SW'(r_rp) + SW'(pop_n);
        n_rp   = (rp_sum >= SW'(MAX_DEPTH)) ? PW'(rp_sum - SW'(MAX_DEPTH)) : PW'(rp_sum);

        n_wp = r_wp;
        if (push_ok) begin
            n_wp = (r_wp == PW'(MAX_DEPTH - 1)) ? '0 : (r_wp + PW'(1));
        end

        n_pushed = r_pushed + TOT_W'(push_ok);
        n_popped = r_popped + TOT_W'(pop_n);
        n_closed = r_closed | i_item.close_stream;
        n_error  = r_error | i_item.raise_error;

        free_n = (r_cap > n_fill) ? (r_cap - n_fill) : '0;
    end

    // State registers; the request state moves only when a result is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_pushed <= '0;
            r_popped <= '0;
            r_closed <= 1'b0;
            r_error  <= 1'b0;
            r_cap    <= CW'(CAP_RST);
        end else begin
            r_cap <= n_cap;
            if (i_step) begin
                r_wp     <= n_wp;
                r_rp     <= n_rp;
                r_fill   <= n_fill;
                r_pushed <= n_pushed;
                r_popped <= n_popped;
                r_closed <= n_closed;
                r_error  <= n_error;
            end
        end
    end

    // Store addresses and the result fields after this request.
    assign o_wr_en        = i_step && push_ok;
    assign o_wr_addr      = r_wp;
    assign o_rd_addr      = n_rp;
    assign o_occupancy    = CNT_W'(n_fill);
    assign o_free_space   = CNT_W'(free_n);
    assign o_total_pushed = n_pushed;
    assign o_total_popped = n_popped;

    always_comb begin
        o_status.push_accepted = push_ok;
        o_status.head_valid    = (n_fill != '0);
        o_status.closed        = n_closed;
        o_status.finished      = n_closed && (n_fill == '0);
        o_status.error         = n_error;
    end

endmodule

>>> rtl/bounded_byte_stream_fifo.sv
// Bounded byte stream FIFO: push one byte or pop a count of bytes per request.
// A request is held in the input register, then in the result register, which is filled
// with the registered read of the byte store. Throughput: one request per cycle while
// results drain on o_rsp, set by the single write and read port of the store.
// Reset (synchronous, active low) clears pointers, counts, totals and flags and sets the
// capacity to 4096 saturated at the depth; the byte store itself is not cleared.
module bounded_byte_stream_fifo #(
    parameter int unsigned MAX_DEPTH = bbsf_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbsf_req_if.sink    i_req,
    bbsf_rsp_if.source  o_rsp,
    bbsf_cfg_if.sink    i_cfg
);
    import bbsf_pkg::*;

    localparam int unsigned PW = $clog2(MAX_DEPTH);
    localparam int unsigned CW = $clog2(MAX_DEPTH + 1);

    t_item             r_item;
    logic              r_in_vld, n_in_vld;
    logic              r_out_vld, n_out_vld;
    t_status           r_status;
    logic [CNT_W-1:0]  r_occupancy;
    logic [CNT_W-1:0]  r_free;
    logic [TOT_W-1:0]  r_pushed;
    logic [TOT_W-1:0]  r_popped;

    logic              in_take;
    logic              step;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [PW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic [CNT_W-1:0]  occupancy_n;
    logic [CNT_W-1:0]  free_n;
    logic [TOT_W-1:0]  pushed_n;
    logic [TOT_W-1:0]  popped_n;
    t_status           status_n;
    logic [TOT_W-1:0]  net_total;

    // Handshake: the held request moves on when the result register is free or drained.
    // Nothing is taken while reset is applied.
    assign step        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_in_vld || step);
    assign in_take     = i_req.valid && i_req.ready;
    assign i_cfg.ready = i_rst_n;

    always_comb begin
        n_in_vld  = in_take ? 1'b1 : (step ? 1'b0 : r_in_vld);
        n_out_vld = step ? 1'b1 : ((r_out_vld && o_rsp.ready) ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command      <= i_req.command;
            r_item.push_byte    <= i_req.push_byte;
            r_item.pop_count    <= i_req.pop_count;
            r_item.close_stream <= i_req.close_stream;
            r_item.raise_error  <= i_req.raise_error;
        end
    end

    // State update.
    bbsf_state #(
        .MAX_DEPTH (MAX_DEPTH),
        .PW        (PW),
        .CW        (CW)
    ) u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_item),
        .i_cfg_we       (i_cfg.valid && i_cfg.ready),
        .i_cfg_cap      (i_cfg.capacity_limit),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .o_occupancy    (occupancy_n),
        .o_free_space   (free_n),
        .o_total_pushed (pushed_n),
        .o_total_popped (popped_n),
        .o_status       (status_n)
    );

    // Byte store; the head byte is read in the same cycle the result is registered.
    bbsf_store #(
        .DEPTH (MAX_DEPTH),
        .AW    (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.push_byte),
        .i_rd_en   (step),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status    <= status_n;
            r_occupancy <= occupancy_n;
            r_free      <= free_n;
            r_pushed    <= pushed_n;
            r_popped    <= popped_n;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.push_accepted = r_status.push_accepted;
    assign o_rsp.head_byte     = r_status.head_valid ? rd_data : '0;
    assign o_rsp.head_valid    = r_status.head_valid;
    assign o_rsp.occupancy     = r_occupancy;
    assign o_rsp.free_space    = r_free;
    assign o_rsp.total_pushed  = r_pushed;
    assign o_rsp.total_popped  = r_popped;
    assign o_rsp.closed_flag   = r_status.closed;
    assign o_rsp.finished_flag = r_status.finished;
    assign o_rsp.error_flag    = r_status.error;

    // Bytes stored less bytes removed is the occupancy, modulo the field width.
    assign net_total = r_pushed - r_popped;

    // While a request is held, the result register is valid in the following cycle.
    a_held_request_reaches_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> r_out_vld
    ) else $error("held request did not reach the result register");

    a_totals_match_occupancy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (net_total[CNT_W-1:0] == r_occupancy)
    ) else $error("running totals disagree with occupancy");

    a_finished_means_closed_and_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status.finished) |-> (r_status.closed && (r_occupancy == '0))
    ) else $error("finished flag without a closed, empty stream");

    a_occupancy_within_depth: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (32'(r_occupancy) <= MAX_DEPTH)
    ) else $error("occupancy exceeds storage depth");

endmodule
